// ----- design/aml_pkg.sv -----
// Package for the audio mixer low-pass unit: register indexes, arithmetic constants,
// microcode control word types and the microcode ROM.
// Has no dependencies of its own.
`default_nettype none
package aml_pkg;

	localparam int NUM_INPUTS   = 4;
	localparam int CHANNELS_DEF = 4;
	localparam int VOL_W        = 7;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int MEM_W        = 18;
	localparam int SUM_W        = 20;
	localparam int PROD_W       = 48;
	localparam int OPND_W       = 24;
	localparam int PC_W         = 4;

	localparam logic [VOL_W-1:0]  PCT_FULL     = 7'd100;
	localparam logic [27:0]       CHVOL_RESET  = 28'd0;
	localparam logic [COEF_W-1:0] COEF_RESET   = 16'h8000;

	// Division by 100 is a multiply by ceil(2^29 / 100) and a shift right by 29.
	// The result is exact for dividends below 2^22.
	localparam logic [22:0] RECIP_MUL   = 23'd5368710;
	localparam int          RECIP_SHIFT = 29;
	// Dividends are held at 100 * 32768, which is enough to saturate the output.
	localparam logic [21:0] DIV_SAT     = 22'd3276800;

	localparam logic signed [21:0] MEM_MAX22 = 22'sd131071;
	localparam logic signed [21:0] MEM_MIN22 = -22'sd131072;
	localparam logic signed [MEM_W-1:0] MEM_MAX = 18'sd131071;
	localparam logic signed [MEM_W-1:0] MEM_MIN = -18'sd131072;
	localparam logic signed [16:0] OUT_MAX17 = 17'sd32767;

	typedef enum logic [2:0] {
		REG_MASTER = 3'd0,
		REG_CHVOL  = 3'd1,
		REG_COEF0  = 3'd2,
		REG_COEF1  = 3'd3,
		REG_COEF2  = 3'd4,
		REG_COEF3  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_XVOL,
		MUL_RECIP,
		MUL_DIFFK,
		MUL_SUMMV
	} mul_op_t;

	typedef enum logic [1:0] {
		ALU_NONE,
		ALU_QUOT,
		ALU_UPD,
		ALU_OUT
	} alu_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_CHLOOP,
		JMP_DONE
	} jmp_t;

	typedef struct packed {
		mul_op_t mul;
		alu_op_t alu;
		jmp_t    jmp;
	} ctrl_t;

	localparam logic [PC_W-1:0] PC_LOOP_TOP = 4'd0;
	localparam logic [PC_W-1:0] PC_LAST     = 4'd8;

	// Steps 0-4 run once per active channel, steps 5-8 once per request.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '{mul: MUL_NONE, alu: ALU_NONE, jmp: JMP_DONE};
		unique case (pc)
			4'd0: c = '{mul: MUL_XVOL,  alu: ALU_NONE, jmp: JMP_NEXT};
			4'd1: c = '{mul: MUL_RECIP, alu: ALU_NONE, jmp: JMP_NEXT};
			4'd2: c = '{mul: MUL_NONE,  alu: ALU_QUOT, jmp: JMP_NEXT};
			4'd3: c = '{mul: MUL_DIFFK, alu: ALU_NONE, jmp: JMP_NEXT};
			4'd4: c = '{mul: MUL_NONE,  alu: ALU_UPD,  jmp: JMP_CHLOOP};
			4'd5: c = '{mul: MUL_SUMMV, alu: ALU_NONE, jmp: JMP_NEXT};
			4'd6: c = '{mul: MUL_RECIP, alu: ALU_NONE, jmp: JMP_NEXT};
			4'd7: c = '{mul: MUL_NONE,  alu: ALU_QUOT, jmp: JMP_NEXT};
			4'd8: c = '{mul: MUL_NONE,  alu: ALU_OUT,  jmp: JMP_DONE};
			default: c = '{mul: MUL_NONE, alu: ALU_NONE, jmp: JMP_DONE};
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- design/audio_mixer_lowpass_unit.sv -----
// Audio mixer with a one-pole low-pass filter per channel, run by a microcoded sequencer
// over one shared 24x24 multiplier. Depends on aml_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, sample_0..sample_3) takes one request holding
//   one signed sample per sound channel. Output channel (out_valid/out_ready,
//   mixed_sample) returns one mixed sample per request, in order.
//   Configuration is an APB-style port, registers at byte addresses 4*i:
//   0 master_volume, 1 channel_volumes, 2..5 lpf_coef_0..3. pready is always high.
// Sequencing:
//   Each active channel takes five microcode steps (gain multiply, divide by 100 as a
//   reciprocal multiply, quotient, filter multiply, memory update); the final mix takes
//   four more. The single multiplier sets this: the steps run one after another, and a
//   new request is taken only once the sequencer has finished the previous request.
//   in_ready is high whenever the sequencer is idle, also while a result waits.
// Reset:
//   arst_n clears the filter memories, loads the register reset values and empties
//   the output register. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register. If the next result is ready to be
//   written while the previous one is still unread, the sequencer holds on its last
//   step until out_ready takes the older one.
`default_nettype none
module audio_mixer_lowpass_unit
	import aml_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// APB-style configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [4:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	// Input channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_0,
	input  wire logic signed [SAMPLE_W-1:0] sample_1,
	input  wire logic signed [SAMPLE_W-1:0] sample_2,
	input  wire logic signed [SAMPLE_W-1:0] sample_3,
	// Output channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      mixed_sample
);

	localparam int NUM_CH = (CHANNELS < NUM_INPUTS) ? CHANNELS : NUM_INPUTS;
	localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

	// Configuration registers
	logic [VOL_W-1:0]  master_q;
	logic [27:0]       chvol_q;
	logic [COEF_W-1:0] coef_q [NUM_INPUTS];

	// Sequencer state
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [1:0]      ch_q;
	logic            out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	// Datapath
	logic signed [SAMPLE_W-1:0] x_q [NUM_INPUTS];
	logic signed [MEM_W-1:0]    mem_q [NUM_INPUTS];
	logic signed [PROD_W-1:0]   p_q;
	logic                       neg_q;
	logic signed [16:0]         q_q;
	logic signed [SUM_W-1:0]    sum_q;

	ctrl_t ctrl;
	logic  in_fire;
	logic  step_en;
	logic  cfg_wr;
	logic [1:0] cfg_coef_idx;

	logic [VOL_W-1:0]         vol_raw;
	logic [VOL_W-1:0]         vol_pct;
	logic [VOL_W-1:0]         master_pct;
	logic signed [OPND_W-1:0] mul_a;
	logic signed [OPND_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] p_abs;
	logic [21:0]              p_sat;
	logic [15:0]              quot;
	logic signed [16:0]       quot_s;
	logic signed [18:0]       diff;
	logic signed [35:0]       fprod;
	logic signed [35:0]       fbiased;
	logic signed [20:0]       delta;
	logic signed [21:0]       mem_sum;
	logic signed [MEM_W-1:0]  mem_new;
	logic signed [SAMPLE_W-1:0] out_clamped;

	assign pready    = 1'b1;
	assign in_ready  = !busy_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign mixed_sample = out_data_q;

	assign ctrl    = ucode(pc_q);
	// The final step waits while an older result is still unread.
	assign step_en = busy_q && !(ctrl.alu == ALU_OUT && out_valid_q && !out_ready);

	// ---------------- Configuration port ----------------
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign cfg_coef_idx = 2'(paddr[4:2] - REG_COEF0);

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[4:2]))
			REG_MASTER: prdata = {25'd0, master_q};
			REG_CHVOL:  prdata = {4'd0, chvol_q};
			REG_COEF0:  prdata = {16'd0, coef_q[0]};
			REG_COEF1:  prdata = {16'd0, coef_q[1]};
			REG_COEF2:  prdata = {16'd0, coef_q[2]};
			REG_COEF3:  prdata = {16'd0, coef_q[3]};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= PCT_FULL;
			chvol_q  <= CHVOL_RESET;
			for (int i = 0; i < NUM_INPUTS; i++) begin
				coef_q[i] <= COEF_RESET;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_MASTER: master_q <= pwdata[VOL_W-1:0];
				REG_CHVOL:  chvol_q  <= pwdata[27:0];
				REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: begin
					coef_q[cfg_coef_idx] <= pwdata[COEF_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ---------------- Sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_LOOP_TOP;
			ch_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_en && ctrl.alu == ALU_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				busy_q <= 1'b1;
				pc_q   <= PC_LOOP_TOP;
				ch_q   <= 2'd0;
			end else if (step_en) begin
				unique case (ctrl.jmp)
					JMP_NEXT: pc_q <= pc_q + 4'd1;
					JMP_CHLOOP: begin
						if (ch_q == CH_LAST) begin
							ch_q <= 2'd0;
							pc_q <= pc_q + 4'd1;
						end else begin
							ch_q <= ch_q + 2'd1;
							pc_q <= PC_LOOP_TOP;
						end
					end
					JMP_DONE: begin
						busy_q <= 1'b0;
						pc_q   <= PC_LOOP_TOP;
					end
					default: ;
				endcase
			end
		end
	end

	// ---------------- Datapath ----------------
	assign vol_raw    = chvol_q[7*ch_q +: VOL_W];
	assign vol_pct    = (vol_raw > PCT_FULL) ? PCT_FULL : vol_raw;
	assign master_pct = (master_q > PCT_FULL) ? PCT_FULL : master_q;

	assign p_abs = p_q[PROD_W-1] ? -p_q : p_q;
	assign p_sat = (p_abs > PROD_W'(DIV_SAT)) ? DIV_SAT : p_abs[21:0];

	assign diff = {{2{q_q[16]}}, q_q} - {mem_q[ch_q][MEM_W-1], mem_q[ch_q]};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_XVOL: begin
				mul_a = {{8{x_q[ch_q][SAMPLE_W-1]}}, x_q[ch_q]};
				mul_b = {17'd0, vol_pct};
			end
			MUL_RECIP: begin
				mul_a = {2'd0, p_sat};
				mul_b = {1'b0, RECIP_MUL};
			end
			MUL_DIFFK: begin
				mul_a = {{5{diff[18]}}, diff};
				mul_b = {8'd0, coef_q[ch_q]};
			end
			MUL_SUMMV: begin
				mul_a = {{4{sum_q[SUM_W-1]}}, sum_q};
				mul_b = {17'd0, master_pct};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Truncating quotient by 100, with the sign taken before the reciprocal multiply.
	assign quot   = p_q[RECIP_SHIFT +: 16];
	assign quot_s = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	// Division by 32768 rounds toward zero, so negative products get a bias first.
	assign fprod   = p_q[35:0];
	assign fbiased = fprod + (fprod[35] ? 36'sd32767 : 36'sd0);
	assign delta   = fbiased[35:15];
	assign mem_sum = {{4{mem_q[ch_q][MEM_W-1]}}, mem_q[ch_q]} + {delta[20], delta};

	always_comb begin
		if (mem_sum > MEM_MAX22) begin
			mem_new = MEM_MAX;
		end else if (mem_sum < MEM_MIN22) begin
			mem_new = MEM_MIN;
		end else begin
			mem_new = mem_sum[MEM_W-1:0];
		end
	end

	// The quotient cannot fall below -32768, so only the upper bound needs a clamp.
	assign out_clamped = (q_q > OUT_MAX17) ? OUT_MAX17[15:0] : q_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_INPUTS; i++) begin
				mem_q[i] <= '0;
			end
		end else if (step_en && ctrl.alu == ALU_UPD) begin
			mem_q[ch_q] <= mem_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q[0] <= sample_0;
			x_q[1] <= sample_1;
			x_q[2] <= sample_2;
			x_q[3] <= sample_3;
			sum_q  <= '0;
		end else if (step_en) begin
			if (ctrl.mul != MUL_NONE) begin
				p_q <= mul_p;
			end
			if (ctrl.mul == MUL_RECIP) begin
				neg_q <= p_q[PROD_W-1];
			end
			unique case (ctrl.alu)
				ALU_NONE: ;
				ALU_QUOT: q_q <= quot_s;
				ALU_UPD:  sum_q <= sum_q + {{2{mem_new[MEM_W-1]}}, mem_new};
				ALU_OUT:  out_data_q <= out_clamped;
			endcase
		end
	end

	// ---------------- Assertions ----------------
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready)
		else $error("request accepted while the sequencer is busy");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= PC_LAST)
		else $error("microcode step counter past the last step");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= CH_LAST)
		else $error("channel counter past the last active channel");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && !busy_q)
		else $error("result appeared without finishing a request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_data_q))
		else $error("unread result was overwritten or dropped");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for audio_mixer_lowpass_unit: random and directed sample requests,
// an in-line model of the mixer and filters, and APB register writes between phases.
// Depends on aml_pkg and the audio_mixer_lowpass_unit RTL.
module testbench
	import aml_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACTIVE_CH = (CHANNELS_DEF < NUM_INPUTS) ? CHANNELS_DEF : NUM_INPUTS;
	localparam int REG_SPAN = 6;
	localparam longint Q15_ONE = 32768;
	localparam longint OUT_HI = 32767;
	localparam longint OUT_LO = -32768;
	localparam logic [15:0] S_MAX = 16'h7FFF;
	localparam logic [15:0] S_MIN = 16'h8000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 140;
	localparam int EXP_DEPTH = 16;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [15:0] sample_0, sample_1, sample_2, sample_3;
	logic out_valid, out_ready;
	logic signed [15:0] mixed_sample;

	// Register image and filter state as the block should hold them.
	logic [6:0] master_gain;
	logic [27:0] chan_gains;
	logic [15:0] lpf_k [4];
	logic signed [17:0] filt_mem [4];

	// Expected mixes in request order; the writer and reader counts never wrap
	// apart by more than a few entries.
	logic signed [15:0] exp_mix [EXP_DEPTH];
	int exp_wr;
	int exp_rd;
	int fails;
	bit quiet;
	int rx_hold_req;

	audio_mixer_lowpass_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
		.out_valid(out_valid), .out_ready(out_ready), .mixed_sample(mixed_sample)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint pct(input logic [6:0] v);
		return (v > PCT_FULL) ? longint'(PCT_FULL) : longint'(v);
	endfunction

	function automatic logic signed [15:0] predict_mix(input logic [3:0][15:0] smp);
		longint acc, x, m, d, mix;
		acc = 0;
		for (int c = 0; c < ACTIVE_CH; c++) begin
			x = longint'($signed(smp[c]));
			x = (x * pct(chan_gains[7*c +: 7])) / longint'(PCT_FULL);
			m = filt_mem[c];
			d = ((x - m) * longint'(lpf_k[c])) / Q15_ONE;
			m = m + d;
			if (m > longint'(MEM_MAX)) m = longint'(MEM_MAX);
			if (m < longint'(MEM_MIN)) m = longint'(MEM_MIN);
			filt_mem[c] = m[17:0];
			acc += m;
		end
		mix = (acc * pct(master_gain)) / longint'(PCT_FULL);
		if (mix > OUT_HI) mix = OUT_HI;
		if (mix < OUT_LO) mix = OUT_LO;
		return mix[15:0];
	endfunction

	function automatic logic [31:0] reg_image(input int idx);
		case (idx)
			REG_MASTER: return {25'd0, master_gain};
			REG_CHVOL:  return {4'd0, chan_gains};
			REG_COEF0:  return {16'd0, lpf_k[0]};
			REG_COEF1:  return {16'd0, lpf_k[1]};
			REG_COEF2:  return {16'd0, lpf_k[2]};
			REG_COEF3:  return {16'd0, lpf_k[3]};
			default:    return 32'd0;
		endcase
	endfunction

	// Mostly short gaps, now and then a long one; none while quiet is set.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return PCT_FULL;
			2: return 7'h7F;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return COEF_RESET;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(1, 2048));
			4: return 16'($urandom_range(30000, 36000));
			default: return 16'($urandom);
		endcase
	endfunction

	// All bus tasks start and end at a falling edge.
	task automatic cfg_check(input int idx);
		logic [31:0] got;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 5'(idx << 2);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got !== reg_image(idx)) begin
			$display("%0t: register %0d readback, expected %0h, got %0h",
				$time, idx, reg_image(idx), got);
			fails++;
		end
	endtask

	task automatic cfg_write(input int idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 5'(idx << 2);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MASTER: master_gain = value[6:0];
			REG_CHVOL:  chan_gains = value[27:0];
			REG_COEF0:  lpf_k[0] = value[15:0];
			REG_COEF1:  lpf_k[1] = value[15:0];
			REG_COEF2:  lpf_k[2] = value[15:0];
			REG_COEF3:  lpf_k[3] = value[15:0];
			default: ;
		endcase
		if (idx < REG_SPAN) cfg_check(idx);
	endtask

	task automatic set_all(input logic [6:0] mg, input logic [27:0] cg,
			input logic [15:0] k0, input logic [15:0] k1,
			input logic [15:0] k2, input logic [15:0] k3);
		cfg_write(REG_MASTER, {25'($urandom), mg});
		cfg_write(REG_CHVOL, {4'($urandom), cg});
		cfg_write(REG_COEF0, {16'($urandom), k0});
		cfg_write(REG_COEF1, {16'($urandom), k1});
		cfg_write(REG_COEF2, {16'($urandom), k2});
		cfg_write(REG_COEF3, {16'($urandom), k3});
	endtask

	task automatic send_mix(input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] s3);
		int gap;
		sample_0 = s0;
		sample_1 = s1;
		sample_2 = s2;
		sample_3 = s3;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		exp_mix[4'(exp_wr)] = predict_mix({s3, s2, s1, s0});
		exp_wr++;
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (exp_wr != exp_rd) @(negedge clk);
	endtask

	task automatic test_reset_values();
		for (int i = 0; i < REG_SPAN; i++) cfg_check(i);
		// All channel gains are zero after reset, so the mix must be silent.
		send_mix(S_MAX, S_MAX, S_MAX, S_MAX);
		send_mix(S_MIN, S_MAX, S_MIN, S_MAX);
		drain();
	endtask

	task automatic test_passthrough_extremes();
		set_all(PCT_FULL, {4{PCT_FULL}}, COEF_RESET, COEF_RESET, COEF_RESET, COEF_RESET);
		send_mix(S_MAX, S_MAX, S_MAX, S_MAX);
		send_mix(S_MIN, S_MIN, S_MIN, S_MIN);
		send_mix(S_MAX, S_MIN, S_MAX, S_MIN);
		send_mix(16'd0, 16'd0, 16'd0, 16'd0);
		send_mix(16'd1, 16'hFFFF, 16'd99, 16'hFF9D);
		drain();
	endtask

	task automatic test_gain_clamp();
		// Gains above one hundred percent act as full scale.
		cfg_write(REG_MASTER, 32'hFFFF_FFFF);
		cfg_write(REG_CHVOL, 32'hFFFF_FFFF);
		send_mix(S_MAX, S_MIN, 16'd12345, 16'hCFC7);
		drain();
		cfg_write(REG_CHVOL, {4'd0, PCT_FULL, 7'd99, 7'd1, 7'd0});
		send_mix(S_MIN, S_MAX, S_MIN, S_MAX);
		send_mix(16'd777, 16'hF000, 16'd50, 16'd3);
		drain();
	endtask

	task automatic test_coef_hold();
		set_all(PCT_FULL, {4{PCT_FULL}}, 16'd0, 16'd0, 16'd0, 16'd0);
		send_mix(S_MIN, S_MIN, S_MIN, S_MIN);
		send_mix(S_MAX, 16'd0, S_MIN, 16'd0);
		drain();
	endtask

	task automatic test_coef_overshoot();
		// Alternating full-scale swings with the largest coefficient drive the
		// filter memories into saturation at both ends.
		set_all(PCT_FULL, {4{PCT_FULL}}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_mix(S_MAX, S_MIN, S_MAX, S_MIN);
		send_mix(S_MIN, S_MAX, S_MIN, S_MAX);
		send_mix(S_MAX, S_MIN, S_MAX, S_MIN);
		send_mix(S_MIN, S_MAX, S_MIN, S_MAX);
		send_mix(S_MIN, S_MIN, S_MIN, S_MIN);
		drain();
	endtask

	task automatic test_master_scale();
		set_all(7'd0, {4{PCT_FULL}}, COEF_RESET, COEF_RESET, 16'd16384, 16'd1);
		send_mix(S_MAX, S_MAX, S_MAX, S_MAX);
		drain();
		cfg_write(REG_MASTER, 32'd1);
		send_mix(S_MIN, S_MIN, 16'd300, S_MAX);
		drain();
		cfg_write(REG_MASTER, 32'd50);
		send_mix(16'd20000, 16'd20000, 16'd0, 16'd0);
		drain();
	endtask

	task automatic test_unused_register();
		// Writes past the last register must leave every register untouched.
		cfg_write(REG_SPAN, 32'hFFFF_FFFF);
		cfg_write(REG_SPAN + 1, 32'd0);
		for (int i = 0; i < REG_SPAN; i++) cfg_check(i);
		send_mix(S_MAX, 16'd1000, S_MIN, 16'd5);
		drain();
	endtask

	task automatic test_random_mix();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			if (phase == 0)
				set_all(7'h7F, 28'hFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else if (phase == 1)
				set_all(7'd0, 28'd0, 16'd0, 16'd0, 16'd0, 16'd0);
			else
				set_all(pick_gain(), {pick_gain(), pick_gain(), pick_gain(), pick_gain()},
					pick_coef(), pick_coef(), pick_coef(), pick_coef());
			quiet = (phase == 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_mix(rand_sample(), rand_sample(), rand_sample(), rand_sample());
			quiet = 1'b0;
		end
		drain();
	endtask

	task automatic test_output_stall();
		set_all(PCT_FULL, {4{PCT_FULL}}, 16'd8000, COEF_RESET, 16'd40000, 16'd1200);
		// The receiver stops for a long stretch while requests keep coming,
		// so the result register fills and the input side has to stall.
		rx_hold_req = RX_HOLD_CYCLES;
		quiet = 1'b1;
		for (int n = 0; n < 12; n++)
			send_mix(rand_sample(), rand_sample(), rand_sample(), rand_sample());
		quiet = 1'b0;
		drain();
	endtask

	// Receiver side: ready with random gaps, plus a long hold when requested.
	initial begin
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				stall = gap_len();
			end
		end
	end

	initial begin
		logic signed [15:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (exp_wr == exp_rd) begin
					$display("%0t: mixed_sample %0d with no request pending",
						$time, mixed_sample);
					fails++;
				end else begin
					want = exp_mix[4'(exp_rd)];
					exp_rd++;
					if (mixed_sample !== want) begin
						$display("%0t: mixed_sample mismatch, expected %0d, got %0d",
							$time, want, mixed_sample);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_0 = '0;
		sample_1 = '0;
		sample_2 = '0;
		sample_3 = '0;
		exp_wr = 0;
		exp_rd = 0;
		fails = 0;
		quiet = 1'b0;
		rx_hold_req = 0;
		master_gain = PCT_FULL;
		chan_gains = CHVOL_RESET;
		for (int c = 0; c < 4; c++) begin
			lpf_k[c] = COEF_RESET;
			filt_mem[c] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_passthrough_extremes();
		test_gain_clamp();
		test_coef_hold();
		test_coef_overshoot();
		test_master_scale();
		test_unused_register();
		test_random_mix();
		test_output_stall();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
